>>> design/rsbs_pkg.sv
// Shared types, codes and defaults for the row stack binary search block.
package rsbs_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int ROW_LEN_DEF  = 32;

    localparam int REQ_W = 3;
    localparam int STAT_W = 3;
    localparam int WORD_W = 32;
    localparam int OUTIDX_W = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTYROW = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data;
        logic [OUTIDX_W-1:0]      position;
        logic [OUTIDX_W-1:0]      rows_below;
        logic [OUTIDX_W-1:0]      row_count;
        logic                     last;
    } res_t;

    typedef struct packed {
        logic elem_we;
        logic open_we;
        logic len_we;
    } mem_ctl_t;

endpackage

>>> design/row_stack_binary_search.sv
// Top level of the row stack with binary search over its rows.
// Append, clear, errors, empty rows and a search of an empty stack answer in the cycle after start.
// Close copies the open row to the element memory; pop and peek emit n results, the last marked.
// Search walks rows top down, loading each length, then reading and comparing probes in turn.
// Reset empties the stack and the open row; memories keep their contents and are not cleared.
// busy is high while a transaction runs and falls as its result shows; results cannot be stalled.
module row_stack_binary_search #(
    parameter int MAX_ROWS = rsbs_pkg::MAX_ROWS_DEF,
    parameter int ROW_LEN  = rsbs_pkg::ROW_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rsbs_pkg::cmd_t cmd,
    output logic           busy,
    output logic           res_valid,
    output rsbs_pkg::res_t res
);

    localparam int ELEMS  = MAX_ROWS * ROW_LEN;
    localparam int EA_W   = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int IDX_W  = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
    localparam int ROWS_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LEN_W  = $clog2(ROW_LEN + 1);

    rsbs_pkg::mem_ctl_t                 ctl;
    logic [EA_W-1:0]                    elem_waddr;
    logic [EA_W-1:0]                    elem_raddr;
    logic signed [rsbs_pkg::WORD_W-1:0] elem_wdata;
    logic signed [rsbs_pkg::WORD_W-1:0] elem_rdata;
    logic [IDX_W-1:0]                   open_waddr;
    logic [IDX_W-1:0]                   open_raddr;
    logic signed [rsbs_pkg::WORD_W-1:0] open_wdata;
    logic signed [rsbs_pkg::WORD_W-1:0] open_rdata;
    logic [ROWS_W-1:0]                  len_waddr;
    logic [ROWS_W-1:0]                  len_raddr;
    logic [LEN_W-1:0]                   len_wdata;
    logic [LEN_W-1:0]                   len_rdata;

    rsbs_seq #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_LEN  (ROW_LEN)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .ctl        (ctl),
        .elem_waddr (elem_waddr),
        .elem_raddr (elem_raddr),
        .elem_wdata (elem_wdata),
        .elem_rdata (elem_rdata),
        .open_waddr (open_waddr),
        .open_raddr (open_raddr),
        .open_wdata (open_wdata),
        .open_rdata (open_rdata),
        .len_waddr  (len_waddr),
        .len_raddr  (len_raddr),
        .len_wdata  (len_wdata),
        .len_rdata  (len_rdata)
    );

    rsbs_store #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_LEN  (ROW_LEN)
    ) u_store (
        .clk        (clk),
        .ctl        (ctl),
        .elem_waddr (elem_waddr),
        .elem_raddr (elem_raddr),
        .elem_wdata (elem_wdata),
        .elem_rdata (elem_rdata),
        .open_waddr (open_waddr),
        .open_raddr (open_raddr),
        .open_wdata (open_wdata),
        .open_rdata (open_rdata),
        .len_waddr  (len_waddr),
        .len_raddr  (len_raddr),
        .len_wdata  (len_wdata),
        .len_rdata  (len_rdata)
    );

endmodule

>>> design/rsbs_store.sv
// Element memory, open row memory and row length table of the row stack.
module rsbs_store #(
    parameter int MAX_ROWS = rsbs_pkg::MAX_ROWS_DEF,
    parameter int ROW_LEN  = rsbs_pkg::ROW_LEN_DEF,
    localparam int ELEMS   = MAX_ROWS * ROW_LEN,
    localparam int EA_W    = (ELEMS > 1) ? $clog2(ELEMS) : 1,
    localparam int IDX_W   = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1,
    localparam int ROWS_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int LEN_W   = $clog2(ROW_LEN + 1)
) (
    input  logic                               clk,
    input  rsbs_pkg::mem_ctl_t                 ctl,
    input  logic [EA_W-1:0]                    elem_waddr,
    input  logic [EA_W-1:0]                    elem_raddr,
    input  logic signed [rsbs_pkg::WORD_W-1:0] elem_wdata,
    output logic signed [rsbs_pkg::WORD_W-1:0] elem_rdata,
    input  logic [IDX_W-1:0]                   open_waddr,
    input  logic [IDX_W-1:0]                   open_raddr,
    input  logic signed [rsbs_pkg::WORD_W-1:0] open_wdata,
    output logic signed [rsbs_pkg::WORD_W-1:0] open_rdata,
    input  logic [ROWS_W-1:0]                  len_waddr,
    input  logic [ROWS_W-1:0]                  len_raddr,
    input  logic [LEN_W-1:0]                   len_wdata,
    output logic [LEN_W-1:0]                   len_rdata
);

    logic signed [rsbs_pkg::WORD_W-1:0] elem_mem [ELEMS];
    logic signed [rsbs_pkg::WORD_W-1:0] open_mem [ROW_LEN];
    logic [LEN_W-1:0]                   len_tab [MAX_ROWS];
    logic signed [rsbs_pkg::WORD_W-1:0] elem_rdata_reg;
    logic signed [rsbs_pkg::WORD_W-1:0] open_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rdata_reg <= elem_mem[elem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.open_we)
        begin
            open_mem[open_waddr] <= open_wdata;
        end
        open_rdata_reg <= open_mem[open_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_tab[len_waddr] <= len_wdata;
        end
    end

    assign elem_rdata = elem_rdata_reg;
    assign open_rdata = open_rdata_reg;
    assign len_rdata  = len_tab[len_raddr];

endmodule

>>> design/rsbs_seq.sv
// Sequencer of the row stack with the shared probe compare unit and the result register.
module rsbs_seq #(
    parameter int MAX_ROWS = rsbs_pkg::MAX_ROWS_DEF,
    parameter int ROW_LEN  = rsbs_pkg::ROW_LEN_DEF,
    localparam int ELEMS   = MAX_ROWS * ROW_LEN,
    localparam int EA_W    = (ELEMS > 1) ? $clog2(ELEMS) : 1,
    localparam int IDX_W   = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1,
    localparam int ROWS_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int LEN_W   = $clog2(ROW_LEN + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  rsbs_pkg::cmd_t                     cmd,
    output logic                               busy,
    output logic                               res_valid,
    output rsbs_pkg::res_t                     res,
    output rsbs_pkg::mem_ctl_t                 ctl,
    output logic [EA_W-1:0]                    elem_waddr,
    output logic [EA_W-1:0]                    elem_raddr,
    output logic signed [rsbs_pkg::WORD_W-1:0] elem_wdata,
    input  logic signed [rsbs_pkg::WORD_W-1:0] elem_rdata,
    output logic [IDX_W-1:0]                   open_waddr,
    output logic [IDX_W-1:0]                   open_raddr,
    output logic signed [rsbs_pkg::WORD_W-1:0] open_wdata,
    input  logic signed [rsbs_pkg::WORD_W-1:0] open_rdata,
    output logic [ROWS_W-1:0]                  len_waddr,
    output logic [ROWS_W-1:0]                  len_raddr,
    output logic [LEN_W-1:0]                   len_wdata,
    input  logic [LEN_W-1:0]                   len_rdata
);

    localparam int DEP_W  = $clog2(MAX_ROWS + 1);
    localparam int SLW    = LEN_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COPY  = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_SROW  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;

    logic [2:0]                         state_reg, state_next;
    logic [DEP_W-1:0]                   depth_reg, depth_next;
    logic [LEN_W-1:0]                   open_len_reg, open_len_next;
    logic                               res_valid_reg, res_valid_next;
    rsbs_pkg::res_t                     res_reg, res_next;
    logic signed [rsbs_pkg::WORD_W-1:0] key_reg, key_next;
    logic [ROWS_W-1:0]                  row_reg, row_next;
    logic [LEN_W-1:0]                   n_reg, n_next;
    logic [LEN_W-1:0]                   cnt_reg, cnt_next;
    logic                               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]                   rd_idx_reg, rd_idx_next;
    logic signed [SLW-1:0]              p_reg, p_next;
    logic signed [SLW-1:0]              k_reg, k_next;
    logic signed [SLW-1:0]              mid_reg, mid_next;
    logic signed [SLW-1:0]              mid_comb;
    logic signed [SLW-1:0]              span;
    logic [ROWS_W-1:0]                  top_row;
    logic [ROWS_W-1:0]                  rd_row;
    logic [IDX_W-1:0]                   rd_col;
    logic [ROWS_W-1:0]                  wr_row;
    logic                               emit_last;

    assign span     = k_reg - p_reg;
    assign mid_comb = p_reg + (span >>> 1);
    assign top_row  = ROWS_W'(depth_reg - DEP_W'(1));
    assign wr_row   = ROWS_W'(depth_reg);
    assign emit_last = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == n_reg);

    assign elem_raddr = EA_W'(rd_row * ROW_LEN) + EA_W'(rd_col);
    assign elem_waddr = EA_W'(wr_row * ROW_LEN) + EA_W'(rd_idx_reg);
    assign elem_wdata = open_rdata;
    assign open_waddr = IDX_W'(open_len_reg);
    assign open_wdata = cmd.value;
    assign open_raddr = IDX_W'(cnt_reg);
    assign len_waddr  = wr_row;
    assign len_wdata  = open_len_reg;

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        open_len_next  = open_len_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        key_next       = key_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        ctl            = '0;
        len_raddr      = row_reg;
        rd_row         = row_reg;
        rd_col         = IDX_W'(cnt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                len_raddr = top_row;
                if (start)
                begin
                    key_next = cmd.value;
                    case (cmd.req_type)
                        rsbs_pkg::REQ_APPEND:
                        begin
                            res_valid_next = 1'b1;
                            res_next.last  = 1'b1;
                            if (open_len_reg == LEN_W'(ROW_LEN))
                            begin
                                res_next.status = rsbs_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ctl.open_we     = 1'b1;
                                open_len_next   = open_len_reg + LEN_W'(1);
                                res_next.status = rsbs_pkg::ST_OK;
                            end
                        end
                        rsbs_pkg::REQ_CLOSE:
                        begin
                            if (depth_reg == DEP_W'(MAX_ROWS))
                            begin
                                res_valid_next  = 1'b1;
                                res_next.last   = 1'b1;
                                res_next.status = rsbs_pkg::ST_OVERFLOW;
                            end
                            else if (open_len_reg == '0)
                            begin
                                ctl.len_we      = 1'b1;
                                depth_next      = depth_reg + DEP_W'(1);
                                res_valid_next  = 1'b1;
                                res_next.last   = 1'b1;
                                res_next.status = rsbs_pkg::ST_EMPTYROW;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_COPY;
                            end
                        end
                        rsbs_pkg::REQ_POP, rsbs_pkg::REQ_PEEK:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_next.last   = 1'b1;
                                res_next.status = rsbs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                row_next = top_row;
                                n_next   = len_rdata;
                                if (cmd.req_type == rsbs_pkg::REQ_POP)
                                begin
                                    depth_next = depth_reg - DEP_W'(1);
                                end
                                if (len_rdata == '0)
                                begin
                                    res_valid_next  = 1'b1;
                                    res_next.last   = 1'b1;
                                    res_next.status = rsbs_pkg::ST_EMPTYROW;
                                end
                                else
                                begin
                                    cnt_next   = '0;
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        rsbs_pkg::REQ_SEARCH:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_next.last   = 1'b1;
                                res_next.status = rsbs_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                row_next   = top_row;
                                state_next = S_SROW;
                            end
                        end
                        rsbs_pkg::REQ_CLEAR:
                        begin
                            depth_next      = '0;
                            open_len_next   = '0;
                            res_valid_next  = 1'b1;
                            res_next.last   = 1'b1;
                            res_next.status = rsbs_pkg::ST_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                ctl.elem_we = rd_valid_reg;
                if (cnt_reg < open_len_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = IDX_W'(cnt_reg);
                    cnt_next      = cnt_reg + LEN_W'(1);
                end
                else
                begin
                    ctl.len_we      = 1'b1;
                    depth_next      = depth_reg + DEP_W'(1);
                    open_len_next   = '0;
                    res_valid_next  = 1'b1;
                    res_next.last   = 1'b1;
                    res_next.status = rsbs_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (rd_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = rsbs_pkg::ST_OK;
                    res_next.data   = elem_rdata;
                    res_next.last   = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (cnt_reg < n_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = IDX_W'(cnt_reg);
                    cnt_next      = cnt_reg + LEN_W'(1);
                end
            end
            S_SROW:
            begin
                p_next     = '0;
                k_next     = $signed({1'b0, len_rdata}) - SLW'(1);
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                rd_col = IDX_W'(mid_comb);
                if (p_reg <= k_reg)
                begin
                    mid_next   = mid_comb;
                    state_next = S_CMP;
                end
                else if (row_reg == '0)
                begin
                    res_valid_next  = 1'b1;
                    res_next.last   = 1'b1;
                    res_next.status = rsbs_pkg::ST_NOTFOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg - ROWS_W'(1);
                    state_next = S_SROW;
                end
            end
            S_CMP:
            begin
                if (elem_rdata == key_reg)
                begin
                    res_valid_next      = 1'b1;
                    res_next.last       = 1'b1;
                    res_next.status     = rsbs_pkg::ST_FOUND;
                    res_next.position   = rsbs_pkg::OUTIDX_W'(mid_reg);
                    res_next.rows_below = rsbs_pkg::OUTIDX_W'(row_reg);
                    state_next          = S_IDLE;
                end
                else
                begin
                    if (elem_rdata < key_reg)
                    begin
                        p_next = mid_reg + SLW'(1);
                    end
                    else
                    begin
                        k_next = mid_reg - SLW'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.row_count = rsbs_pkg::OUTIDX_W'(depth_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            open_len_reg  <= '0;
            res_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            open_len_reg  <= open_len_next;
            res_valid_reg <= res_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        key_reg    <= key_next;
        row_reg    <= row_next;
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        rd_idx_reg <= rd_idx_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        mid_reg    <= mid_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> tb/rsbs_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every row stack transaction and compares each result strobe.
module rsbs_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  rsbs_pkg::cmd_t cmd,
    input  logic           res_valid,
    input  rsbs_pkg::res_t res,
    output int             fail_count,
    output int             pending
);

    localparam int ROWS = rsbs_pkg::MAX_ROWS_DEF;
    localparam int COLS = rsbs_pkg::ROW_LEN_DEF;

    logic signed [rsbs_pkg::WORD_W-1:0] stored_rows [ROWS][COLS];
    logic signed [rsbs_pkg::WORD_W-1:0] open_words [COLS];
    int             row_len [ROWS];
    int             depth;
    int             open_len;
    int             errors;
    rsbs_pkg::res_t expected_results [$];
    rsbs_pkg::res_t oldest;

    function automatic void queue_result(rsbs_pkg::res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic rsbs_pkg::res_t status_result(logic [rsbs_pkg::STAT_W-1:0] status);
        rsbs_pkg::res_t r;
        r = '0;
        r.status = status;
        r.row_count = depth[rsbs_pkg::OUTIDX_W-1:0];
        r.last = 1'b1;
        return r;
    endfunction

    task automatic emit_top_row(input bit remove);
        int             r;
        int             n;
        rsbs_pkg::res_t item;
        if (depth == 0)
        begin
            queue_result(status_result(rsbs_pkg::ST_EMPTY));
        end
        else
        begin
            r = depth - 1;
            n = row_len[r];
            if (remove)
            begin
                depth = r;
            end
            if (n == 0)
            begin
                queue_result(status_result(rsbs_pkg::ST_EMPTYROW));
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    item = status_result(rsbs_pkg::ST_OK);
                    item.data = stored_rows[r][i];
                    item.last = (i == n - 1);
                    queue_result(item);
                end
            end
        end
    endtask

    task automatic search_rows(input logic signed [rsbs_pkg::WORD_W-1:0] key);
        int             lo;
        int             hi;
        int             mid;
        bit             hit;
        rsbs_pkg::res_t item;
        hit = 1'b0;
        for (int d = depth - 1; d >= 0 && !hit; d--)
        begin
            lo = 0;
            hi = row_len[d] - 1;
            while (lo <= hi && !hit)
            begin
                mid = (hi - lo) / 2 + lo;
                if (stored_rows[d][mid] == key)
                begin
                    hit = 1'b1;
                    item = status_result(rsbs_pkg::ST_FOUND);
                    item.position = mid[rsbs_pkg::OUTIDX_W-1:0];
                    item.rows_below = d[rsbs_pkg::OUTIDX_W-1:0];
                    queue_result(item);
                end
                else if (stored_rows[d][mid] < key)
                begin
                    lo = mid + 1;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        if (!hit)
        begin
            queue_result(status_result(rsbs_pkg::ST_NOTFOUND));
        end
    endtask

    task automatic predict_request(input rsbs_pkg::cmd_t c);
        logic [rsbs_pkg::STAT_W-1:0] close_status;
        case (c.req_type)
            rsbs_pkg::REQ_APPEND:
            begin
                if (open_len >= COLS)
                begin
                    queue_result(status_result(rsbs_pkg::ST_OVERFLOW));
                end
                else
                begin
                    open_words[open_len] = c.value;
                    open_len++;
                    queue_result(status_result(rsbs_pkg::ST_OK));
                end
            end
            rsbs_pkg::REQ_CLOSE:
            begin
                if (depth >= ROWS)
                begin
                    queue_result(status_result(rsbs_pkg::ST_OVERFLOW));
                end
                else
                begin
                    for (int i = 0; i < open_len; i++)
                    begin
                        stored_rows[depth][i] = open_words[i];
                    end
                    row_len[depth] = open_len;
                    close_status = (open_len == 0) ? rsbs_pkg::ST_EMPTYROW : rsbs_pkg::ST_OK;
                    depth++;
                    open_len = 0;
                    queue_result(status_result(close_status));
                end
            end
            rsbs_pkg::REQ_POP:
            begin
                emit_top_row(1'b1);
            end
            rsbs_pkg::REQ_PEEK:
            begin
                emit_top_row(1'b0);
            end
            rsbs_pkg::REQ_SEARCH:
            begin
                search_rows(c.value);
            end
            rsbs_pkg::REQ_CLEAR:
            begin
                depth = 0;
                open_len = 0;
                queue_result(status_result(rsbs_pkg::ST_OK));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth = 0;
            open_len = 0;
            errors = 0;
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, res.status);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("status", oldest.status, res.status);
                    check_field("data", oldest.data, res.data);
                    check_field("position", oldest.position, res.position);
                    check_field("rows_below", oldest.rows_below, res.rows_below);
                    check_field("row_count", oldest.row_count, res.row_count);
                    check_field("last", oldest.last, res.last);
                end
            end
            if (start && !busy)
            begin
                predict_request(cmd);
            end
            fail_count <= errors;
            pending <= expected_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the row stack testbench: clock, reset, stimulus, watchdog and verdict.
module tb_top;

    localparam int IDLE_LIMIT = 4000;
    localparam int DIRECTED_ITEMS = 25;
    localparam int PHASE_ITEMS = 120;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic           res_valid;
    rsbs_pkg::cmd_t cmd;
    rsbs_pkg::res_t res;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   items_sent;
    int   idle_cycles;
    int   phase_idle [3] = '{0, 56, 21};
    logic signed [rsbs_pkg::WORD_W-1:0] known_keys [$];

    row_stack_binary_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    rsbs_checker stack_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic [rsbs_pkg::REQ_W-1:0] req,
                                input logic signed [rsbs_pkg::WORD_W-1:0] val);
        rsbs_pkg::cmd_t c;
        bit             was_idle;
        c.req_type = req;
        c.value = val;
        while ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(negedge clk);
            was_idle = !busy;
            @(posedge clk);
        end
        while (!was_idle);
        if (req <= rsbs_pkg::REQ_CLEAR)
        begin
            items_sent++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic append_sorted(input int n, input bit wide);
        logic signed [rsbs_pkg::WORD_W-1:0] v;
        v = wide ? $urandom : $urandom_range(0, 4000) - 2000;
        for (int i = 0; i < n; i++)
        begin
            send_request(rsbs_pkg::REQ_APPEND, v);
            known_keys.insert(known_keys.size(), v);
            if (known_keys.size() > 64)
            begin
                known_keys.delete(0);
            end
            v = v + (wide ? $urandom_range(1, 1 << 24) : $urandom_range(0, 3));
        end
    endtask

    task automatic search_key();
        int sel;
        logic signed [rsbs_pkg::WORD_W-1:0] key;
        sel = $urandom_range(0, 99);
        if (known_keys.size() == 0 || sel >= 80)
        begin
            key = $urandom;
        end
        else
        begin
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            if (sel >= 70)
            begin
                key = key + 1;
            end
            else if (sel >= 60)
            begin
                key = key - 1;
            end
        end
        send_request(rsbs_pkg::REQ_SEARCH, key);
    endtask

    task automatic run_scenario();
        int sel;
        int size_sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            size_sel = $urandom_range(0, 9);
            if (size_sel == 0)
            begin
                append_sorted(0, 1'b0);
            end
            else if (size_sel < 9)
            begin
                append_sorted($urandom_range(1, 6), $urandom_range(0, 3) == 0);
            end
            else
            begin
                append_sorted($urandom_range(7, 32), $urandom_range(0, 1) == 1);
            end
            send_request(rsbs_pkg::REQ_CLOSE, $urandom);
        end
        else if (sel < 64)
        begin
            search_key();
        end
        else if (sel < 72)
        begin
            send_request(rsbs_pkg::REQ_PEEK, $urandom);
        end
        else if (sel < 79)
        begin
            send_request(rsbs_pkg::REQ_POP, $urandom);
        end
        else if (sel < 82)
        begin
            send_request(rsbs_pkg::REQ_CLEAR, $urandom);
        end
        else
        begin
            send_request(rsbs_pkg::REQ_W'($urandom_range(0, 7)), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_pct = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(rsbs_pkg::REQ_SEARCH, 32'sd5);
        send_request(rsbs_pkg::REQ_POP, 32'sd0);
        send_request(rsbs_pkg::REQ_PEEK, 32'sd0);
        send_request(rsbs_pkg::REQ_CLOSE, 32'sd0);
        send_request(rsbs_pkg::REQ_PEEK, 32'sd0);
        send_request(rsbs_pkg::REQ_SEARCH, 32'sd0);
        send_request(rsbs_pkg::REQ_POP, 32'sd0);
        send_request(rsbs_pkg::REQ_APPEND, 32'sh8000_0000);
        send_request(rsbs_pkg::REQ_APPEND, -32'sd1);
        send_request(rsbs_pkg::REQ_APPEND, 32'sd0);
        send_request(rsbs_pkg::REQ_APPEND, 32'sh7fff_ffff);
        send_request(rsbs_pkg::REQ_CLOSE, 32'sh7fff_ffff);
        send_request(rsbs_pkg::REQ_SEARCH, 32'sh8000_0000);
        send_request(rsbs_pkg::REQ_SEARCH, 32'sh7fff_ffff);
        send_request(rsbs_pkg::REQ_SEARCH, -32'sd1);
        send_request(rsbs_pkg::REQ_SEARCH, 32'sd1);
        send_request(rsbs_pkg::REQ_PEEK, 32'sd0);
        send_request(3'd6, 32'sh5555_aaaa);
        send_request(3'd7, 32'shaaaa_5555);
        send_request(rsbs_pkg::REQ_APPEND, 32'sd3);
        send_request(rsbs_pkg::REQ_CLEAR, 32'sd0);
        send_request(rsbs_pkg::REQ_POP, 32'sd0);
        send_request(rsbs_pkg::REQ_APPEND, 32'sd7);
        send_request(rsbs_pkg::REQ_CLOSE, 32'sd0);
        send_request(rsbs_pkg::REQ_POP, 32'sd0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_idle[ph];
            if (ph == 1)
            begin
                append_sorted(34, 1'b0);
                send_request(rsbs_pkg::REQ_CLOSE, 32'sd0);
                repeat (17)
                begin
                    append_sorted(1, 1'b0);
                    send_request(rsbs_pkg::REQ_CLOSE, 32'sd0);
                end
                repeat (4) search_key();
            end
            while (items_sent < DIRECTED_ITEMS + PHASE_ITEMS * (ph + 1))
            begin
                run_scenario();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
